[rtl/core/dpb_pkg.sv]
`timescale 1ns / 1ps
// dpb_pkg: shared widths, register indexes and reset values for the depth pixel
// back-projection block. Depends on nothing; imported by the top level.

package dpb_pkg;

  // input field widths
  localparam int PIX_W        = 12;
  localparam int COLOR_W      = 8;
  localparam int NUM_COLORS   = 4;

  // register field widths
  localparam int FOCAL_W      = 24;
  localparam int FOCAL_HALF_W = 12;
  localparam int CENTER_W     = 16;
  localparam int SUBPIX_BITS  = 4;
  localparam int COEF_W       = 16;
  localparam int ROW_W        = 64;

  // fixed-point positions
  localparam int CAM_FRAC     = 8;   // camera coordinates are Q.8 mm
  localparam int PROJ_SHIFT   = 20;  // Q.28 product down to Q.8
  localparam int WORLD_FRAC   = 22;  // Q1.14 rotation times Q.8 camera

  // configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FOCAL_INV_X = 3'd0;
  localparam cfg_idx_t REG_FOCAL_INV_Y = 3'd1;
  localparam cfg_idx_t REG_CENTER_X    = 3'd2;
  localparam cfg_idx_t REG_CENTER_Y    = 3'd3;
  localparam cfg_idx_t REG_ROW_X       = 3'd4;
  localparam cfg_idx_t REG_ROW_Y       = 3'd5;
  localparam cfg_idx_t REG_ROW_Z       = 3'd6;

  localparam logic [FOCAL_W-1:0]  FOCAL_INV_RST = 24'd33554;
  localparam logic [CENTER_W-1:0] CENTER_X_RST  = 16'd5112;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 16'd3832;
  localparam logic [ROW_W-1:0]    ROW_X_RST     = 64'h0000_0000_0000_4000;
  localparam logic [ROW_W-1:0]    ROW_Y_RST     = 64'h0000_0000_4000_0000;
  localparam logic [ROW_W-1:0]    ROW_Z_RST     = 64'h0000_4000_0000_0000;

  typedef logic [NUM_COLORS*COLOR_W-1:0] color_t;

endpackage

[rtl/core/depth_pixel_backprojection_top.sv]
`timescale 1ns / 1ps
// depth_pixel_backprojection_top: seven-stage pipeline turning depth pixels into
// world-space points. Depends on dpb_pkg.
//
// usage
//   in_* channel: one pixel per transaction. in_tdata holds col, row, depth and
//   the four colour bytes; in_tuser is the depth-valid flag.
//   out_* channel: one point per pixel, in order. out_tdata holds x, y, z and the
//   colour bytes; out_tuser is the point-valid flag. a pixel with its valid flag
//   low gives a point with flag low and all of out_tdata zero.
//   cfg_*: register write port, taken on any edge with cfg_we high. write only
//   while the pipeline is empty; indexes past the last register are ignored.
// timing
//   one pixel per clock is sustained while out_tready stays high: every stage
//   holds one pixel, and the depth of the pipeline is set by the two cut
//   multiplies (|d|*depth, then the two halves of the reciprocal) and the 3x3
//   transform multiply and sum.
// reset and stall
//   rst_n low clears every stage valid bit and loads the default intrinsics
//   (identity transform). when out_tready is low the output stage holds its
//   point; earlier stages keep filling bubbles, so in_tready drops only once
//   every stage holds a pixel.

module depth_pixel_backprojection_top
  import dpb_pkg::*;
#(
  parameter int DEPTH_BITS = 16,
  parameter int COORD_BITS = 20,
  localparam int IN_W  = ((2*PIX_W + DEPTH_BITS + NUM_COLORS*COLOR_W + 7) / 8) * 8,
  localparam int OUT_W = ((3*COORD_BITS + NUM_COLORS*COLOR_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // pixel input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // pixel_col, pixel_row, depth_mm, red, green, blue, extra
  input  logic                  in_tuser,   // depth_valid
  // point output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // point_x, point_y, point_z, out_red, out_green, out_blue, out_extra
  output logic                  out_tuser   // point_valid
);

  localparam int NSTG  = 7;
  localparam int DX_W  = CENTER_W + 1;                 // signed col*16 - cx
  localparam int MAG_W = CENTER_W;                     // |dx|
  localparam int MW    = MAG_W + DEPTH_BITS;           // |dx| * depth
  localparam int PPW   = MW + FOCAL_HALF_W;            // one reciprocal half
  localparam int PW    = MW + FOCAL_W;                 // full product, Q.28
  localparam int CW    = PW - PROJ_SHIFT + 2;          // signed camera coordinate, Q.8
  localparam int PRW   = COEF_W + CW;                  // rotation product
  localparam int AW    = PRW + 3;                      // sum of four terms plus rounding
  localparam int QW    = AW - WORLD_FRAC;              // integer mm before saturation
  localparam int SW    = QW + COORD_BITS;              // room to compare against the limits

  // input field offsets
  localparam int COL_LSB   = 0;
  localparam int ROW_LSB   = PIX_W;
  localparam int DEPTH_LSB = 2*PIX_W;
  localparam int COLOR_LSB = 2*PIX_W + DEPTH_BITS;

  localparam logic [PW:0] PROJ_HALF = {{(PW-10){1'b0}}, 1'b1, 10'd0} << 1;
  localparam logic signed [AW-1:0] WORLD_HALF = {{(AW-WORLD_FRAC+1){1'b0}},
                                                 1'b1, {(WORLD_FRAC-2){1'b0}}} << 1;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  // configuration registers
  logic [FOCAL_W-1:0]  inv_fx_r, inv_fy_r;
  logic [CENTER_W-1:0] cx_r, cy_r;
  logic [ROW_W-1:0]    row_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r <= FOCAL_INV_RST;
      inv_fy_r <= FOCAL_INV_RST;
      cx_r     <= CENTER_X_RST;
      cy_r     <= CENTER_Y_RST;
      row_r[0] <= ROW_X_RST;
      row_r[1] <= ROW_Y_RST;
      row_r[2] <= ROW_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_INV_X: inv_fx_r <= cfg_wdata[FOCAL_W-1:0];
        REG_FOCAL_INV_Y: inv_fy_r <= cfg_wdata[FOCAL_W-1:0];
        REG_CENTER_X:    cx_r     <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:    cy_r     <= cfg_wdata[CENTER_W-1:0];
        REG_ROW_X:       row_r[0] <= cfg_wdata;
        REG_ROW_Y:       row_r[1] <= cfg_wdata;
        REG_ROW_Z:       row_r[2] <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or when the stage
  // after it loads, so bubbles close up behind a stalled output
  // ---------------------------------------------------------------------------
  logic [NSTG:1] v_r;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: offsets from the principal point, split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic [DX_W-1:0]       dx_full, dy_full;
  logic [MAG_W-1:0]      s1_adx_nxt, s1_ady_nxt;
  logic [MAG_W-1:0]      s1_adx_r, s1_ady_r;
  logic                  s1_nx_r, s1_ny_r, s1_pv_r;
  logic [DEPTH_BITS-1:0] s1_depth_r;
  color_t                s1_color_r;

  always_comb begin
    dx_full = {1'b0, in_tdata[COL_LSB +: PIX_W], {SUBPIX_BITS{1'b0}}} - {1'b0, cx_r};
    dy_full = {1'b0, in_tdata[ROW_LSB +: PIX_W], {SUBPIX_BITS{1'b0}}} - {1'b0, cy_r};
    s1_adx_nxt = dx_full[DX_W-1] ? MAG_W'(-dx_full) : dx_full[MAG_W-1:0];
    s1_ady_nxt = dy_full[DX_W-1] ? MAG_W'(-dy_full) : dy_full[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_adx_r   <= s1_adx_nxt;
      s1_ady_r   <= s1_ady_nxt;
      s1_nx_r    <= dx_full[DX_W-1];
      s1_ny_r    <= dy_full[DX_W-1];
      s1_depth_r <= in_tdata[DEPTH_LSB +: DEPTH_BITS];
      s1_pv_r    <= in_tuser;
      s1_color_r <= in_tdata[COLOR_LSB +: NUM_COLORS*COLOR_W];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: |d| * depth
  // ---------------------------------------------------------------------------
  logic [MW-1:0]         s2_mx_r, s2_my_r;
  logic                  s2_nx_r, s2_ny_r, s2_pv_r;
  logic [DEPTH_BITS-1:0] s2_depth_r;
  color_t                s2_color_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_mx_r    <= MW'(s1_adx_r) * MW'(s1_depth_r);
      s2_my_r    <= MW'(s1_ady_r) * MW'(s1_depth_r);
      s2_nx_r    <= s1_nx_r;
      s2_ny_r    <= s1_ny_r;
      s2_depth_r <= s1_depth_r;
      s2_pv_r    <= s1_pv_r;
      s2_color_r <= s1_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: partial products against the high and low reciprocal halves
  // ---------------------------------------------------------------------------
  logic [PPW-1:0]        s3_ax_r, s3_bx_r, s3_ay_r, s3_by_r;
  logic                  s3_nx_r, s3_ny_r, s3_pv_r;
  logic [DEPTH_BITS-1:0] s3_depth_r;
  color_t                s3_color_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_ax_r    <= PPW'(s2_mx_r) * PPW'(inv_fx_r[FOCAL_W-1:FOCAL_HALF_W]);
      s3_bx_r    <= PPW'(s2_mx_r) * PPW'(inv_fx_r[FOCAL_HALF_W-1:0]);
      s3_ay_r    <= PPW'(s2_my_r) * PPW'(inv_fy_r[FOCAL_W-1:FOCAL_HALF_W]);
      s3_by_r    <= PPW'(s2_my_r) * PPW'(inv_fy_r[FOCAL_HALF_W-1:0]);
      s3_nx_r    <= s2_nx_r;
      s3_ny_r    <= s2_ny_r;
      s3_depth_r <= s2_depth_r;
      s3_pv_r    <= s2_pv_r;
      s3_color_r <= s2_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: join the halves, round at Q.16 then truncate the magnitude to Q.8, restore sign
  // ---------------------------------------------------------------------------
  logic [PW:0]            psum_x, psum_y;
  logic signed [CW-1:0]   magx_s, magy_s;
  logic signed [CW-1:0]   s4_cam_nxt [3];
  logic signed [CW-1:0]   s4_cam_r [3];
  logic                   s4_pv_r;
  color_t                 s4_color_r;

  always_comb begin
    psum_x = (PW+1)'({s3_ax_r, {FOCAL_HALF_W{1'b0}}}) + (PW+1)'(s3_bx_r) + PROJ_HALF;
    psum_y = (PW+1)'({s3_ay_r, {FOCAL_HALF_W{1'b0}}}) + (PW+1)'(s3_by_r) + PROJ_HALF;
    magx_s = {1'b0, psum_x[PW:PROJ_SHIFT]};
    magy_s = {1'b0, psum_y[PW:PROJ_SHIFT]};
    s4_cam_nxt[0] = s3_nx_r ? -magx_s : magx_s;
    s4_cam_nxt[1] = s3_ny_r ? -magy_s : magy_s;
    s4_cam_nxt[2] = CW'({s3_depth_r, {CAM_FRAC{1'b0}}});  // z is the depth itself
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_cam_r   <= s4_cam_nxt;
      s4_pv_r    <= s3_pv_r;
      s4_color_r <= s3_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: rotation products, one per matrix entry
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] s5_prod_nxt [3][3];
  logic signed [PRW-1:0] s5_prod_r [3][3];
  logic                  s5_pv_r;
  color_t                s5_color_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s5_prod_nxt[i][k] = PRW'($signed(row_r[i][COEF_W*k +: COEF_W])) * PRW'(s4_cam_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_prod_r  <= s5_prod_nxt;
      s5_pv_r    <= s4_pv_r;
      s5_color_r <= s4_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: sum with translation, round half up to integer mm
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] acc [3];
  logic signed [QW-1:0] s6_q_r [3];
  logic                 s6_pv_r;
  color_t               s6_color_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(s5_prod_r[i][0]) + AW'(s5_prod_r[i][1]) + AW'(s5_prod_r[i][2])
             + (AW'($signed(row_r[i][3*COEF_W +: COEF_W])) <<< WORLD_FRAC)
             + WORLD_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        s6_q_r[i] <= acc[i][AW-1:WORLD_FRAC];  // floor shift
      end
      s6_pv_r    <= s5_pv_r;
      s6_color_r <= s5_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: saturate, blank invalid pixels, output register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]   qe [3];
  logic [COORD_BITS-1:0]  sat [3];
  logic [OUT_W-1:0]       s7_data_nxt;
  logic [OUT_W-1:0]       s7_data_r;
  logic                   s7_pv_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i] = SW'(s6_q_r[i]);
      if (qe[i] > SAT_HI) begin
        sat[i] = SAT_HI[COORD_BITS-1:0];
      end else if (qe[i] < SAT_LO) begin
        sat[i] = SAT_LO[COORD_BITS-1:0];
      end else begin
        sat[i] = qe[i][COORD_BITS-1:0];
      end
    end
    if (s6_pv_r) begin
      s7_data_nxt = OUT_W'({s6_color_r, sat[2], sat[1], sat[0]});
    end else begin
      s7_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_data_r <= s7_data_nxt;
      s7_pv_r   <= s6_pv_r;
    end
  end

  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = s7_data_r;
  assign out_tuser  = s7_pv_r;

endmodule

[rtl/core/dpb_checker.sv]
`timescale 1ns / 1ps
// dpb_checker: port-level assertions for depth_pixel_backprojection_top and the
// bind that attaches them. Depends on the top level's port list.

module dpb_checker #(
  parameter int COORD_BITS = 20,
  localparam int OUT_W = ((3*COORD_BITS + 32 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  // a stalled point holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // a point without valid depth carries no position and no colour
  a_invalid_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid point carries nonzero data");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with nothing waiting at the output every stage can move, so input is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output is empty");

endmodule

bind depth_pixel_backprojection_top dpb_checker #(
  .COORD_BITS(COORD_BITS)
) u_dpb_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for depth_pixel_backprojection_top. Streams pixels under
// several intrinsic/pose settings and checks every point against a built-in predictor.
// Depends on dpb_pkg and the block's top level.

module tb_top;
  import dpb_pkg::*;

  localparam int DEPTH_BITS  = 16;
  localparam int COORD_BITS  = 20;
  localparam int IN_W        = ((2*PIX_W + DEPTH_BITS + NUM_COLORS*COLOR_W + 7) / 8) * 8;
  localparam int OUT_W       = ((3*COORD_BITS + NUM_COLORS*COLOR_W + 7) / 8) * 8;

  // pipeline latency; the tail wait covers it twice over
  localparam int PIPE_LATENCY = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_GAP      = 14;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 240;
  localparam int PRINT_CAP    = 40;

  // index past the last register, used to check that such writes are dropped
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  // Q1.14 rotation coefficients
  localparam logic [COEF_W-1:0] Q14_HALF     = 16'h2000;
  localparam logic [COEF_W-1:0] Q14_NEG_HALF = 16'hE000;
  localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS-1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS-1));
  localparam logic [COORD_BITS-1:0] RAIL_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] RAIL_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [PIX_W-1:0]                     col;
    logic [PIX_W-1:0]                     row;
    logic [DEPTH_BITS-1:0]                depth;
    logic                                 depth_valid;
    logic [NUM_COLORS-1:0][COLOR_W-1:0]   colour;     // [0] red .. [3] extra
  } pixel_t;

  typedef struct packed {
    logic                                 valid;
    logic signed [COORD_BITS-1:0]         x;
    logic signed [COORD_BITS-1:0]         y;
    logic signed [COORD_BITS-1:0]         z;
    logic [NUM_COLORS-1:0][COLOR_W-1:0]   colour;
  } point_t;

  // intrinsics and the three transform rows, as held by the block
  typedef struct packed {
    logic [FOCAL_W-1:0]                   inv_fx;
    logic [FOCAL_W-1:0]                   inv_fy;
    logic [CENTER_W-1:0]                  cx;
    logic [CENTER_W-1:0]                  cy;
    logic [2:0][ROW_W-1:0]                xform;      // [0] world x row .. [2] world z row
  } calib_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // pixel_col, pixel_row, depth_mm, red, green, blue, extra
  logic                  in_tuser;   // depth_valid
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // point_x, point_y, point_z, out_red, out_green, out_blue, out_extra
  logic                  out_tuser;  // point_valid

  // shared bench state
  point_t      expected_points[$];   // predicted points, oldest first
  calib_t      calib;                // mirror of the block's registers
  int unsigned src_gap_max;          // per-transaction idle bound on the pixel side
  int unsigned sink_gap_max;         // per-transaction stall bound on the point side
  int unsigned hold_len;             // one-shot long stall request for the point side
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_missing;
  int unsigned n_checked;
  int unsigned n_clipped;
  int unsigned n_calibs;
  int unsigned cycle_count;

  depth_pixel_backprojection_top #(
    .DEPTH_BITS (DEPTH_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // |d| * depth * inv, with d in Q.4 and inv in Q0.24, taken down to Q.8 mm.
  // the block splits the reciprocal in two 12-bit halves and rounds the low
  // partial product at bit 12 before dropping the last 8 bits, so the round
  // happens at Q.16 and the final step to Q.8 truncates; sign goes back on last
  function automatic longint project_q8(input longint d, input logic [DEPTH_BITS-1:0] depth,
                                        input logic [FOCAL_W-1:0] inv);
    logic [63:0] prod;
    prod = 64'(d < 0 ? -d : d) * 64'(depth) * 64'(inv);
    prod = (prod + (64'd1 << (FOCAL_HALF_W-1))) >> FOCAL_HALF_W;
    prod = prod >> (PROJ_SHIFT - FOCAL_HALF_W);
    return (d < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // one transform row applied to a Q.8 camera point; sum is exact in Q.22,
  // then rounded half toward +inf (add half, floor) and clamped to the rails
  function automatic logic [COORD_BITS-1:0] to_world(input logic [ROW_W-1:0] coeffs,
                                                     input longint x, input longint y,
                                                     input longint z);
    longint acc;
    acc = longint'($signed(coeffs[15:0]))  * x
        + longint'($signed(coeffs[31:16])) * y
        + longint'($signed(coeffs[47:32])) * z
        + (longint'($signed(coeffs[63:48])) <<< WORLD_FRAC);
    acc = (acc + (longint'(1) <<< (WORLD_FRAC-1))) >>> WORLD_FRAC;
    if (acc > COORD_MAX) begin
      acc = COORD_MAX;
    end else if (acc < COORD_MIN) begin
      acc = COORD_MIN;
    end
    return acc[COORD_BITS-1:0];
  endfunction

  // pixel to world point; missing depth gives an all-zero point with valid low
  function automatic point_t backproject_pixel(input pixel_t p, input calib_t c);
    point_t pt;
    longint cam_x;
    longint cam_y;
    longint cam_z;
    pt = '0;
    if (p.depth_valid) begin
      cam_x = project_q8((longint'(p.col) <<< SUBPIX_BITS) - longint'(c.cx), p.depth, c.inv_fx);
      cam_y = project_q8((longint'(p.row) <<< SUBPIX_BITS) - longint'(c.cy), p.depth, c.inv_fy);
      cam_z = longint'(p.depth) <<< CAM_FRAC;
      pt.valid  = 1'b1;
      pt.x      = to_world(c.xform[0], cam_x, cam_y, cam_z);
      pt.y      = to_world(c.xform[1], cam_x, cam_y, cam_z);
      pt.z      = to_world(c.xform[2], cam_x, cam_y, cam_z);
      pt.colour = p.colour;
    end
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic calib_t default_calib();
    calib_t c;
    c.inv_fx   = FOCAL_INV_RST;
    c.inv_fy   = FOCAL_INV_RST;
    c.cx       = CENTER_X_RST;
    c.cy       = CENTER_Y_RST;
    c.xform[0] = ROW_X_RST;
    c.xform[1] = ROW_Y_RST;
    c.xform[2] = ROW_Z_RST;
    return c;
  endfunction

  function automatic logic [ROW_W-1:0] make_row(input logic [COEF_W-1:0] r0,
                                                input logic [COEF_W-1:0] r1,
                                                input logic [COEF_W-1:0] r2,
                                                input logic [COEF_W-1:0] t_mm);
    return {t_mm, r2, r1, r0};
  endfunction

  // wild: every bit random; otherwise a camera-like setup with bounded rotations
  function automatic calib_t random_calib(input bit wild);
    calib_t c;
    if (wild) begin
      c.inv_fx = FOCAL_W'($urandom);
      c.inv_fy = FOCAL_W'($urandom);
      c.cx     = CENTER_W'($urandom);
      c.cy     = CENTER_W'($urandom);
      for (int k = 0; k < 3; k++) begin
        c.xform[k] = {$urandom, $urandom};
      end
    end else begin
      c.inv_fx = FOCAL_W'($urandom_range(70000, 8000));
      c.inv_fy = FOCAL_W'($urandom_range(70000, 8000));
      c.cx     = CENTER_W'($urandom_range(20000, 1000));
      c.cy     = CENTER_W'($urandom_range(20000, 1000));
      for (int k = 0; k < 3; k++) begin
        c.xform[k] = make_row(COEF_W'($urandom_range(32768, 0) - 16384),
                              COEF_W'($urandom_range(32768, 0) - 16384),
                              COEF_W'($urandom_range(32768, 0) - 16384),
                              COEF_W'($urandom));
      end
    end
    return c;
  endfunction

  function automatic pixel_t make_pixel(input int unsigned col, input int unsigned row,
                                        input int unsigned depth, input bit depth_valid,
                                        input logic [31:0] rgbx);
    pixel_t p;
    p.col         = PIX_W'(col);
    p.row         = PIX_W'(row);
    p.depth       = DEPTH_BITS'(depth);
    p.depth_valid = depth_valid;
    p.colour      = rgbx;
    return p;
  endfunction

  // mostly sensor-like depths, with some full-range and rail values mixed in
  function automatic pixel_t random_pixel();
    int unsigned depth;
    case ($urandom_range(9, 0))
      0: depth = $urandom_range(65535, 0);
      1: depth = $urandom_range(1, 0) ? 65535 : 0;
      default: depth = $urandom_range(8000, 200);
    endcase
    return make_pixel($urandom_range(4095, 0), $urandom_range(4095, 0), depth,
                      $urandom_range(6, 0) != 0, $urandom);
  endfunction

  // one register write; cfg_we is left high so back-to-back writes need one
  // assignment per edge, the caller drops it after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_calib(input calib_t c);
    write_reg(REG_FOCAL_INV_X, CFG_DATA_W'(c.inv_fx));
    write_reg(REG_FOCAL_INV_Y, CFG_DATA_W'(c.inv_fy));
    write_reg(REG_CENTER_X,    CFG_DATA_W'(c.cx));
    write_reg(REG_CENTER_Y,    CFG_DATA_W'(c.cy));
    write_reg(REG_ROW_X,       c.xform[0]);
    write_reg(REG_ROW_Y,       c.xform[1]);
    write_reg(REG_ROW_Z,       c.xform[2]);
    cfg_we <= 1'b0;
    calib = c;
    n_calibs++;
  endtask

  // offer one pixel after a random idle gap and record its point on acceptance;
  // in_tvalid stays high on return so a zero gap gives back-to-back transactions
  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    point_t      want;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = backproject_pixel(p, calib);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.colour, p.depth, p.row, p.col};
    in_tuser  <= p.depth_valid;
    do @(posedge clk); while (!in_tready);
    expected_points.push_back(want);
    n_sent++;
    if (!p.depth_valid) begin
      n_missing++;
    end
  endtask

  // stop offering and let every predicted point come out; every pixel gives
  // exactly one point, so an empty queue means the pipeline is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    n_errors++;
    if (n_errors <= PRINT_CAP) begin
      $display("[%0t] point %0d: %s is %0d, expected %0d", $time, n_checked, field, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers still at their reset values: image corners, centre, rails
  task automatic test_reset_defaults();
    send_pixel(make_pixel(0, 0, 0, 1'b1, 32'h0000_0000));          // zero depth is still a point
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'hFFFF_FFFF));
    send_pixel(make_pixel(319, 239, 1000, 1'b1, 32'h1234_5678));   // next to the principal point
    send_pixel(make_pixel(320, 240, 1000, 1'b1, 32'h8765_4321));
    send_pixel(make_pixel(2048, 17, 40000, 1'b0, 32'hDEAD_BEEF));  // missing depth, colour must clear
    send_pixel(make_pixel(0, 4095, 1, 1'b1, 32'hAA55_AA55));
    send_pixel(make_pixel(4095, 0, 32768, 1'b1, 32'h55AA_55AA));
    send_pixel(make_pixel(4095, 4095, 65535, 1'b0, 32'hFFFF_FFFF));
  endtask

  // all-zero and all-one registers, both saturation rails, rounding ties
  task automatic test_calib_extremes();
    calib_t c;

    wait_idle();
    load_calib('0);
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'hFFFF_FFFF));
    send_pixel(make_pixel(0, 0, 65535, 1'b1, 32'h0102_0304));

    wait_idle();
    load_calib('1);
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'hFFFF_FFFF));
    send_pixel(make_pixel(0, 0, 1, 1'b1, 32'h0000_0000));
    send_pixel(make_pixel(4095, 0, 65535, 1'b1, 32'hF0F0_0F0F));

    // everything pushed to the positive rail
    wait_idle();
    c          = default_calib();
    c.inv_fx   = '1;
    c.inv_fy   = '1;
    c.cx       = '0;
    c.cy       = '0;
    c.xform[0] = make_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX);
    c.xform[1] = c.xform[0];
    c.xform[2] = c.xform[0];
    load_calib(c);
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'h1111_1111));
    send_pixel(make_pixel(0, 0, 0, 1'b1, 32'h2222_2222));          // translation only

    // and to the negative rail
    wait_idle();
    c.xform[0] = make_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX);
    c.xform[1] = c.xform[0];
    c.xform[2] = c.xform[0];
    load_calib(c);
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'h3333_3333));
    send_pixel(make_pixel(0, 0, 0, 1'b1, 32'h4444_4444));

    // half-scale depth: odd depths land exactly on .5 mm, on both signs
    wait_idle();
    c          = default_calib();
    c.xform[0] = make_row('0, '0, Q14_HALF, '0);
    c.xform[1] = make_row('0, '0, Q14_NEG_HALF, '0);
    c.xform[2] = make_row('0, '0, '0, COEF_NEG_MAX);
    load_calib(c);
    send_pixel(make_pixel(100, 200, 1, 1'b1, 32'h5555_5555));
    send_pixel(make_pixel(100, 200, 3, 1'b1, 32'h6666_6666));
    send_pixel(make_pixel(100, 200, 65535, 1'b1, 32'h7777_7777));
  endtask

  // a write past the last register must leave every register as it was
  task automatic test_stray_index();
    wait_idle();
    load_calib(default_calib());
    @(posedge clk);
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_pixel(make_pixel(4095, 4095, 65535, 1'b1, 32'h9999_9999));
    send_pixel(make_pixel(10, 3000, 5000, 1'b1, 32'hABCD_EF01));
    send_pixel(random_pixel());
  endtask

  // point side holds off long enough for the pipeline to fill and push back
  // on the pixel side, while pixels keep coming with no gaps
  task automatic test_backpressure();
    wait_idle();
    load_calib(random_calib(1'b0));
    src_gap_max  = 0;
    sink_gap_max = 0;
    hold_len     = HOLD_CYCLES;
    repeat (48) send_pixel(random_pixel());
  endtask

  // long random streams, alternating camera-like and fully random settings,
  // with idle/stall bounds redrawn per chunk so some stretches run flat out
  task automatic test_random_streams();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      load_calib(random_calib(ph % 2 == 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          src_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : MAX_GAP;
          sink_gap_max = ($urandom_range(2, 0) == 0) ? 0 : MAX_GAP;
        end
        send_pixel(random_pixel());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // point side: random stalls per transaction, plus the one long hold
  // ---------------------------------------------------------------------------
  initial begin : drive_out_ready
    int unsigned stall;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        // long hold counted here, independent of what the pixel side does
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = (sink_gap_max == 0) ? 0 : $urandom_range(sink_gap_max, 0);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted point against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_points
    point_t got;
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.valid  = out_tuser;
      got.x      = out_tdata[0 +: COORD_BITS];
      got.y      = out_tdata[COORD_BITS +: COORD_BITS];
      got.z      = out_tdata[2*COORD_BITS +: COORD_BITS];
      got.colour = out_tdata[3*COORD_BITS +: NUM_COLORS*COLOR_W];
      if (expected_points.size() == 0) begin
        report_mismatch("point with nothing pending, point_valid", got.valid, 0);
      end else begin
        want = expected_points.pop_front();
        if (got.valid !== want.valid) begin
          report_mismatch("point_valid", got.valid, want.valid);
        end
        if (got.x !== want.x) begin
          report_mismatch("point_x", $signed(got.x), $signed(want.x));
        end
        if (got.y !== want.y) begin
          report_mismatch("point_y", $signed(got.y), $signed(want.y));
        end
        if (got.z !== want.z) begin
          report_mismatch("point_z", $signed(got.z), $signed(want.z));
        end
        for (int k = 0; k < NUM_COLORS; k++) begin
          if (got.colour[k] !== want.colour[k]) begin
            report_mismatch($sformatf("colour byte %0d", k), got.colour[k], want.colour[k]);
          end
        end
        if (want.valid && (want.x == RAIL_HI || want.x == RAIL_LO || want.y == RAIL_HI ||
                           want.y == RAIL_LO || want.z == RAIL_HI || want.z == RAIL_LO)) begin
          n_clipped++;
        end
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d points still pending", cycle_count,
             expected_points.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_FOCAL_INV_X;
    cfg_wdata    <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= 1'b0;
    src_gap_max  = MAX_GAP;
    sink_gap_max = MAX_GAP;
    hold_len     = 0;
    n_errors     = 0;
    n_sent       = 0;
    n_missing    = 0;
    n_checked    = 0;
    n_clipped    = 0;
    n_calibs     = 0;
    calib        = default_calib();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_calib_extremes();
    test_stray_index();
    test_backpressure();
    test_random_streams();

    // drain, then give the pipeline time to show any stray extra point
    wait_idle();
    repeat (2*PIPE_LATENCY) @(posedge clk);

    $display("pixels sent %0d (%0d with missing depth), points checked %0d, clipped %0d",
             n_sent, n_missing, n_checked, n_clipped);
    $display("register settings loaded %0d, mismatches %0d", n_calibs, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
